// ----- rtl/core/smx_pkg.sv -----
package smx_pkg;

  // Default sizes of the machine.
  localparam int DATA_DEPTH_DEF = 64;
  localparam int CALL_DEPTH_DEF = 16;
  localparam int NUM_REGS_DEF   = 8;
  localparam int RAM_WORDS_DEF  = 1024;
  localparam int ADDR_WIDTH_DEF = 16;

  // Operand mode masks.
  localparam logic [2:0] REG_BIT      = 3'd1;
  localparam logic [2:0] CONSTANT_BIT = 3'd2;
  localparam logic [2:0] MEMORY_BIT   = 3'd4;

  // Opcodes.
  localparam logic [4:0] K_PUSH = 5'd0;
  localparam logic [4:0] K_POP  = 5'd1;
  localparam logic [4:0] K_ADD  = 5'd2;
  localparam logic [4:0] K_SUB  = 5'd3;
  localparam logic [4:0] K_DIV  = 5'd4;
  localparam logic [4:0] K_MUL  = 5'd5;
  localparam logic [4:0] K_IN   = 5'd6;
  localparam logic [4:0] K_OUT  = 5'd7;
  localparam logic [4:0] K_HLT  = 5'd8;
  localparam logic [4:0] K_JMP  = 5'd9;
  localparam logic [4:0] K_CALL = 5'd10;
  localparam logic [4:0] K_RET  = 5'd11;
  localparam logic [4:0] K_SQRT = 5'd12;
  localparam logic [4:0] K_SQR  = 5'd13;
  localparam logic [4:0] K_MOD  = 5'd14;
  localparam logic [4:0] K_IDIV = 5'd15;
  localparam logic [4:0] K_JNE  = 5'd16;
  localparam logic [4:0] K_JGE  = 5'd17;
  localparam logic [4:0] K_JLZ  = 5'd18;
  localparam logic [4:0] K_JGZ  = 5'd19;
  localparam logic [4:0] K_DRAW = 5'd20;
  localparam logic [4:0] K_JE   = 5'd21;

  // Error codes.
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_DIV_ZERO = 3'd1;
  localparam logic [2:0] E_NEG_SQRT = 3'd2;
  localparam logic [2:0] E_UNKNOWN  = 3'd3;
  localparam logic [2:0] E_UNDER    = 3'd4;
  localparam logic [2:0] E_OVER     = 3'd5;
  localparam logic [2:0] E_OPERAND  = 3'd6;

  // One classified instruction as it sits in the queue.
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  mode;
    logic [2:0]  ri;
    logic [31:0] imm;
    logic [15:0] tgt;
    logic [31:0] inv;
    logic        unknown;
    logic [1:0]  need;
    logic        opnd;
  } smx_item_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic [32:0] num;
    logic [31:0] den;
  } smx_areq_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
    logic [32:0] rem;
  } smx_aresp_t;

endpackage

// ----- rtl/core/stack_machine_executor_core.sv -----
// Stack machine executor. Each input transaction carries one decoded instruction
// (opcode, operand mode, register number, immediate, jump target and the value for
// the in instruction); each produces exactly one output transaction with the next
// fetch address, an optional value from the out instruction, the halt flag and the
// sticky error code.
// A two-entry queue takes instructions while the executor is busy or the receiver
// stalls; the executor holds its result in an output register until it is taken and
// starts the next instruction only once that register is free.
// Mul and sqr run on one registered 32x32 multiplier, sqrt takes 16 steps of the
// root unit, and div, mod and idiv take 33 steps of the restoring divider. One
// instruction is executed at a time, so a new one starts only once the last has
// its result. Once halted, each instruction returns the frozen status.
// After reset the data RAM is cleared one word per cycle, all RAM_WORDS words
// (1024 by default), and no instruction is accepted during that pass. Reset also
// clears the stack pointers, registers, instruction pointer and halt flag.
module stack_machine_executor_core #(
  parameter int DATA_DEPTH = smx_pkg::DATA_DEPTH_DEF,
  parameter int CALL_DEPTH = smx_pkg::CALL_DEPTH_DEF,
  parameter int NUM_REGS   = smx_pkg::NUM_REGS_DEF,
  parameter int RAM_WORDS  = smx_pkg::RAM_WORDS_DEF,
  parameter int ADDR_WIDTH = smx_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_kind,
  input  logic [2:0]  in_arg_mode,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_immediate,
  input  logic [15:0] in_jump_target,
  input  logic [31:0] in_in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_addr,
  output logic        out_out_valid,
  output logic [31:0] out_out_value,
  output logic        out_halted,
  output logic [2:0]  out_error_code
);

  logic                q_valid;
  logic                q_pop;
  logic                clearing;
  smx_pkg::smx_item_t  q_item;
  smx_pkg::smx_areq_t  areq;
  smx_pkg::smx_aresp_t aresp;

  // Front end: classifies each instruction and queues it.
  smx_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (clearing),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_arg_mode    (in_arg_mode),
    .in_reg_index   (in_reg_index),
    .in_immediate   (in_immediate),
    .in_jump_target (in_jump_target),
    .in_in_value    (in_in_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Shared iterative divider and square root unit.
  smx_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .resp  (aresp)
  );

  // Back end: stacks, registers, RAM and the execution sequencer.
  smx_back #(
    .DATA_DEPTH (DATA_DEPTH),
    .CALL_DEPTH (CALL_DEPTH),
    .NUM_REGS   (NUM_REGS),
    .RAM_WORDS  (RAM_WORDS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .areq           (areq),
    .aresp          (aresp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_addr  (out_next_addr),
    .out_out_valid  (out_out_valid),
    .out_out_value  (out_out_value),
    .out_halted     (out_halted),
    .out_error_code (out_error_code)
  );

endmodule

// ----- rtl/core/smx_front.sv -----
module smx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hold,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        in_kind,
  input  logic [2:0]        in_arg_mode,
  input  logic [2:0]        in_reg_index,
  input  logic [31:0]       in_immediate,
  input  logic [15:0]       in_jump_target,
  input  logic [31:0]       in_in_value,
  output logic              q_valid,
  output smx_pkg::smx_item_t q_item,
  input  logic              q_pop
);

  smx_pkg::smx_item_t q_r [2];
  logic               wp_r, wp_nxt;
  logic               rp_r, rp_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  smx_pkg::smx_item_t cls;
  logic               push;

  // Operand count and class of each opcode.
  always_comb begin
    cls.kind    = in_kind;
    cls.mode    = in_arg_mode;
    cls.ri      = in_reg_index;
    cls.imm     = in_immediate;
    cls.tgt     = in_jump_target;
    cls.inv     = in_in_value;
    cls.unknown = in_kind > smx_pkg::K_JE;
    cls.opnd    = (in_kind == smx_pkg::K_PUSH) || (in_kind == smx_pkg::K_POP);
    if (in_kind inside {smx_pkg::K_ADD, smx_pkg::K_SUB, smx_pkg::K_DIV, smx_pkg::K_MUL,
                        smx_pkg::K_MOD, smx_pkg::K_IDIV, smx_pkg::K_JNE, smx_pkg::K_JGE,
                        smx_pkg::K_JE}) begin
      cls.need = 2'd2;
    end else if (in_kind inside {smx_pkg::K_OUT, smx_pkg::K_SQRT, smx_pkg::K_SQR,
                                 smx_pkg::K_JLZ, smx_pkg::K_JGZ}) begin
      cls.need = 2'd1;
    end else begin
      cls.need = 2'd0;
    end
  end

  assign in_ready = (cnt_r != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ----- rtl/core/smx_arith.sv -----
module smx_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  smx_pkg::smx_areq_t  req,
  output smx_pkg::smx_aresp_t resp
);

  localparam logic [5:0] DIV_STEPS  = 6'd33;
  localparam logic [5:0] SQRT_STEPS = 6'd16;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sq_r, sq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [33:0] acc;
  logic [31:0] trial;

  // Restoring division, one quotient bit per cycle; square root one result bit per
  // cycle with rem_r as the remainder and quo_r as the partial root.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bit_nxt  = bit_r;
    acc      = {rem_r, quo_r[32]};
    trial    = rem_r[31:0] - (quo_r[31:0] + bit_r);
    if (req.start) begin
      busy_nxt = 1'b1;
      sq_nxt   = req.sqrt_mode;
      den_nxt  = req.den;
      bit_nxt  = 32'h4000_0000;
      if (req.sqrt_mode) begin
        cnt_nxt = SQRT_STEPS;
        rem_nxt = req.num;
        quo_nxt = 33'd0;
      end else begin
        cnt_nxt = DIV_STEPS;
        rem_nxt = 33'd0;
        quo_nxt = req.num;
      end
    end else if (busy_r) begin
      if (sq_r) begin
        if (rem_r[31:0] >= quo_r[31:0] + bit_r) begin
          rem_nxt = {1'b0, trial};
          quo_nxt = {1'b0, (quo_r[31:0] >> 1) + bit_r};
        end else begin
          quo_nxt = {1'b0, quo_r[31:0] >> 1};
        end
        bit_nxt = bit_r >> 2;
      end else begin
        if (acc >= {2'b00, den_r}) begin
          rem_nxt = 33'(acc - {2'b00, den_r});
          quo_nxt = {quo_r[31:0], 1'b1};
        end else begin
          rem_nxt = acc[32:0];
          quo_nxt = {quo_r[31:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sq_r  <= sq_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    bit_r <= bit_nxt;
  end

  assign resp.done = done_r;
  assign resp.quo  = quo_r;
  assign resp.rem  = rem_r;

endmodule

// ----- rtl/core/smx_back.sv -----
module smx_back #(
  parameter int DATA_DEPTH = smx_pkg::DATA_DEPTH_DEF,
  parameter int CALL_DEPTH = smx_pkg::CALL_DEPTH_DEF,
  parameter int NUM_REGS   = smx_pkg::NUM_REGS_DEF,
  parameter int RAM_WORDS  = smx_pkg::RAM_WORDS_DEF,
  parameter int ADDR_WIDTH = smx_pkg::ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  smx_pkg::smx_item_t  q_item,
  output logic                q_pop,
  output logic                clearing,
  output smx_pkg::smx_areq_t  areq,
  input  smx_pkg::smx_aresp_t aresp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_next_addr,
  output logic                out_out_valid,
  output logic [31:0]         out_out_value,
  output logic                out_halted,
  output logic [2:0]          out_error_code
);

  localparam int DSW = $clog2(DATA_DEPTH + 1);
  localparam int DIW = $clog2(DATA_DEPTH);
  localparam int CSW = $clog2(CALL_DEPTH + 1);
  localparam int CIW = $clog2(CALL_DEPTH);
  localparam int RIW = $clog2(NUM_REGS);
  localparam int RAW = $clog2(RAM_WORDS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDA   = 3'd2;
  localparam logic [2:0] ST_RDB   = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_MULF  = 3'd6;
  localparam logic [2:0] ST_WAIT  = 3'd7;

  localparam logic [1:0] W_REG = 2'd0;
  localparam logic [1:0] W_SCR = 2'd1;
  localparam logic [1:0] W_RAM = 2'd2;

  function automatic logic [31:0] half(input logic [31:0] x);
    return 32'($signed(x + {31'd0, x[31]}) >>> 1);
  endfunction

  function automatic logic [32:0] mag33(input logic [33:0] x);
    logic [33:0] m;
    m = x[33] ? (~x + 34'd1) : x;
    return m[32:0];
  endfunction

  logic [2:0]            state_r, state_nxt;
  logic [DSW-1:0]        dsp_r, dsp_nxt;
  logic [CSW-1:0]        csp_r, csp_nxt;
  logic [31:0]           regs_r [NUM_REGS];
  logic [31:0]           regs_nxt [NUM_REGS];
  logic [31:0]           scr_r, scr_nxt;
  logic [ADDR_WIDTH-1:0] ip_r, ip_nxt;
  logic                  stop_r, stop_nxt;
  logic [2:0]            err_r, err_nxt;
  smx_pkg::smx_item_t    item_r, item_nxt;
  logic [31:0]           a_r, a_nxt;
  logic [31:0]           opv_r, opv_nxt;
  logic                  opbad_r, opbad_nxt;
  logic [1:0]            where_r, where_nxt;
  logic [RAW-1:0]        clr_r, clr_nxt;
  logic signed [31:0]    mx_r, mx_nxt, my_r, my_nxt;
  logic signed [63:0]    prod_r, prod_nxt;
  logic                  negq_r, negq_nxt, negr_r, negr_nxt;
  logic                  ov_r, ov_nxt;
  logic [15:0]           oaddr_r, oaddr_nxt;
  logic                  oovalid_r, oovalid_nxt;
  logic [31:0]           oval_r, oval_nxt;
  logic                  ohalt_r, ohalt_nxt;
  logic [2:0]            oerr_r, oerr_nxt;

  logic [31:0]           dstack [DATA_DEPTH];
  logic [ADDR_WIDTH-1:0] cstack [CALL_DEPTH];
  logic [31:0]           ram [RAM_WORDS];
  logic [31:0]           ds_q, ram_q;
  logic [ADDR_WIDTH-1:0] cs_q;
  logic                  ds_we, cs_we, ram_we;
  logic [DIW-1:0]        ds_waddr, ds_raddr;
  logic [31:0]           ds_wdata, ram_wdata;
  logic [CIW-1:0]        cs_waddr;
  logic [ADDR_WIDTH-1:0] cs_wdata;
  logic [RAW-1:0]        ram_waddr;

  logic [DSW-1:0]        dm1, dm2;
  logic [CSW-1:0]        cm1;
  logic                  fin;
  logic                  res_ov;
  logic [31:0]           res_val;
  logic [31:0]           v, val, ha, hb, wq;
  logic                  have, bad;
  logic [ADDR_WIDTH-1:0] nip, ip2, nipp, tgt;
  logic [33:0]           sq_div;

  assign dm1      = dsp_r - DSW'(1);
  assign dm2      = dsp_r - DSW'(2);
  assign cm1      = csp_r - CSW'(1);
  assign ds_raddr = (state_r == ST_RDA) ? dm1[DIW-1:0] : dm2[DIW-1:0];
  assign clearing = state_r == ST_CLEAR;

  always_comb begin
    state_nxt   = state_r;
    dsp_nxt     = dsp_r;
    csp_nxt     = csp_r;
    regs_nxt    = regs_r;
    scr_nxt     = scr_r;
    ip_nxt      = ip_r;
    stop_nxt    = stop_r;
    err_nxt     = err_r;
    item_nxt    = item_r;
    a_nxt       = a_r;
    opv_nxt     = opv_r;
    opbad_nxt   = opbad_r;
    where_nxt   = where_r;
    clr_nxt     = clr_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    prod_nxt    = prod_r;
    negq_nxt    = negq_r;
    negr_nxt    = negr_r;
    ov_nxt      = ov_r;
    oaddr_nxt   = oaddr_r;
    oovalid_nxt = oovalid_r;
    oval_nxt    = oval_r;
    ohalt_nxt   = ohalt_r;
    oerr_nxt    = oerr_r;
    q_pop       = 1'b0;
    ds_we       = 1'b0;
    ds_waddr    = dm2[DIW-1:0];
    ds_wdata    = 32'd0;
    cs_we       = 1'b0;
    cs_waddr    = csp_r[CIW-1:0];
    cs_wdata    = ip_r + ADDR_WIDTH'(2);
    ram_we      = 1'b0;
    ram_waddr   = opv_r[RAW-1:0];
    ram_wdata   = 32'd0;
    areq        = '0;
    fin         = 1'b0;
    res_ov      = 1'b0;
    res_val     = 32'd0;
    v           = 32'd0;
    val         = 32'd0;
    have        = 1'b0;
    bad         = 1'b0;
    ha          = half(a_r);
    hb          = half(ds_q);
    wq          = 32'd0;
    nip         = ip_r + ADDR_WIDTH'(1);
    ip2         = ip_r + ADDR_WIDTH'(2);
    nipp        = ip_r + ADDR_WIDTH'(2) + ADDR_WIDTH'(item_r.mode[0])
                  + ADDR_WIDTH'(item_r.mode[1]);
    tgt         = ADDR_WIDTH'(item_r.tgt);
    sq_div      = {ds_q[31], ds_q, 1'b0};

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + RAW'(1);
        if (clr_r == RAW'(RAM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && (!ov_r || out_ready)) begin
          q_pop = 1'b1;
          if (stop_r) begin
            fin = 1'b1;
          end else begin
            item_nxt  = q_item;
            state_nxt = ST_RDA;
          end
        end
      end
      ST_RDA: begin
        where_nxt = W_REG;
        if ((item_r.mode & smx_pkg::REG_BIT) != 3'd0) begin
          if ({29'd0, item_r.ri} >= 32'(NUM_REGS)) begin
            bad = 1'b1;
          end else begin
            v = regs_r[RIW'(item_r.ri)];
          end
          have = 1'b1;
        end
        if ((item_r.mode & smx_pkg::CONSTANT_BIT) != 3'd0) begin
          v         = have ? v + item_r.imm : item_r.imm;
          where_nxt = W_SCR;
          have      = 1'b1;
        end
        if (!have) begin
          bad = 1'b1;
        end
        if ((item_r.mode & smx_pkg::MEMORY_BIT) != 3'd0) begin
          where_nxt = W_RAM;
          if (v[31] || (v >= 32'(RAM_WORDS))) begin
            bad = 1'b1;
          end
        end
        opv_nxt   = v;
        opbad_nxt = bad;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        a_nxt     = ds_q;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        if (item_r.unknown) begin
          stop_nxt = 1'b1;
          err_nxt  = smx_pkg::E_UNKNOWN;
        end else if (item_r.opnd) begin
          val = (where_r == W_RAM) ? ram_q : opv_r;
          if (opbad_r) begin
            stop_nxt = 1'b1;
            err_nxt  = smx_pkg::E_OPERAND;
          end else if (item_r.kind == smx_pkg::K_PUSH) begin
            if (dsp_r >= DSW'(DATA_DEPTH)) begin
              stop_nxt = 1'b1;
              err_nxt  = smx_pkg::E_OVER;
            end else begin
              ds_we    = 1'b1;
              ds_waddr = dsp_r[DIW-1:0];
              ds_wdata = {val[30:0], 1'b0};
              dsp_nxt  = dsp_r + DSW'(1);
              if (item_r.mode[1]) begin
                scr_nxt = opv_r;
              end
              ip_nxt = nipp;
            end
          end else begin
            if (dsp_r == DSW'(0)) begin
              stop_nxt = 1'b1;
              err_nxt  = smx_pkg::E_UNDER;
            end else begin
              dsp_nxt = dm1;
              if (item_r.mode[1]) begin
                scr_nxt = opv_r;
              end
              case (where_r)
                W_REG: regs_nxt[RIW'(item_r.ri)] = ha;
                W_SCR: scr_nxt = ha;
                default: begin
                  ram_we    = 1'b1;
                  ram_wdata = ha;
                end
              endcase
              ip_nxt = nipp;
            end
          end
        end else if (dsp_r < DSW'(item_r.need)) begin
          stop_nxt = 1'b1;
          err_nxt  = smx_pkg::E_UNDER;
        end else begin
          case (item_r.kind)
            smx_pkg::K_ADD, smx_pkg::K_SUB: begin
              ds_we    = 1'b1;
              ds_wdata = (item_r.kind == smx_pkg::K_ADD) ? ds_q + a_r : ds_q - a_r;
              dsp_nxt  = dm1;
              ip_nxt   = nip;
            end
            smx_pkg::K_DIV: begin
              if (a_r == 32'd0) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_DIV_ZERO;
              end else begin
                fin        = 1'b0;
                areq.start = 1'b1;
                areq.num   = mag33(sq_div);
                areq.den   = mag33({{2{a_r[31]}}, a_r})[31:0];
                negq_nxt   = a_r[31] ^ ds_q[31];
                state_nxt  = ST_WAIT;
              end
            end
            smx_pkg::K_MOD, smx_pkg::K_IDIV: begin
              if (ha == 32'd0) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_DIV_ZERO;
              end else begin
                fin        = 1'b0;
                areq.start = 1'b1;
                areq.num   = mag33({{2{hb[31]}}, hb});
                areq.den   = mag33({{2{ha[31]}}, ha})[31:0];
                negq_nxt   = ha[31] ^ hb[31];
                negr_nxt   = hb[31];
                state_nxt  = ST_WAIT;
              end
            end
            smx_pkg::K_SQRT: begin
              if (ha[31]) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_NEG_SQRT;
              end else begin
                fin            = 1'b0;
                areq.start     = 1'b1;
                areq.sqrt_mode = 1'b1;
                areq.num       = {1'b0, ha};
                state_nxt      = ST_WAIT;
              end
            end
            smx_pkg::K_MUL: begin
              fin       = 1'b0;
              mx_nxt    = $signed(a_r);
              my_nxt    = $signed(ds_q);
              state_nxt = ST_MUL;
            end
            smx_pkg::K_SQR: begin
              fin       = 1'b0;
              mx_nxt    = $signed(ha);
              my_nxt    = $signed(ha);
              state_nxt = ST_MUL;
            end
            smx_pkg::K_IN: begin
              if (dsp_r >= DSW'(DATA_DEPTH)) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_OVER;
              end else begin
                ds_we    = 1'b1;
                ds_waddr = dsp_r[DIW-1:0];
                ds_wdata = {item_r.inv[30:0], 1'b0};
                dsp_nxt  = dsp_r + DSW'(1);
                ip_nxt   = nip;
              end
            end
            smx_pkg::K_OUT: begin
              res_ov  = 1'b1;
              res_val = a_r;
              dsp_nxt = dm1;
              ip_nxt  = nip;
            end
            smx_pkg::K_HLT: begin
              stop_nxt = 1'b1;
              err_nxt  = smx_pkg::E_NONE;
            end
            smx_pkg::K_JMP: ip_nxt = tgt;
            smx_pkg::K_CALL: begin
              if (csp_r >= CSW'(CALL_DEPTH)) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_OVER;
              end else begin
                cs_we   = 1'b1;
                csp_nxt = csp_r + CSW'(1);
                ip_nxt  = tgt;
              end
            end
            smx_pkg::K_RET: begin
              if (csp_r == CSW'(0)) begin
                stop_nxt = 1'b1;
                err_nxt  = smx_pkg::E_UNDER;
              end else begin
                csp_nxt = cm1;
                ip_nxt  = cs_q;
              end
            end
            smx_pkg::K_JNE: ip_nxt = (a_r != ds_q) ? tgt : ip2;
            smx_pkg::K_JGE: ip_nxt = ($signed(a_r) >= $signed(ds_q)) ? tgt : ip2;
            smx_pkg::K_JLZ: ip_nxt = a_r[31] ? tgt : ip2;
            smx_pkg::K_JGZ: ip_nxt = ($signed(a_r) > 32'sd0) ? tgt : ip2;
            smx_pkg::K_JE:  ip_nxt = (a_r == ds_q) ? tgt : ip2;
            smx_pkg::K_DRAW: ip_nxt = nip;
            default: begin
              stop_nxt = 1'b1;
              err_nxt  = smx_pkg::E_UNKNOWN;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = mx_r * my_r;
        state_nxt = ST_MULF;
      end
      ST_MULF: begin
        ds_we = 1'b1;
        if (item_r.kind == smx_pkg::K_MUL) begin
          // Halve the product, rounding toward zero.
          ds_wdata = 32'((prod_r + {63'd0, prod_r[63]}) >>> 1);
          dsp_nxt  = dm1;
        end else begin
          ds_waddr = dm1[DIW-1:0];
          ds_wdata = {prod_r[30:0], 1'b0};
        end
        ip_nxt    = nip;
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_WAIT: begin
        if (aresp.done) begin
          ds_we = 1'b1;
          case (item_r.kind)
            smx_pkg::K_SQRT: begin
              ds_waddr = dm1[DIW-1:0];
              ds_wdata = {aresp.quo[30:0], 1'b0};
            end
            smx_pkg::K_MOD: begin
              wq       = negr_r ? (~aresp.rem[31:0] + 32'd1) : aresp.rem[31:0];
              ds_wdata = {wq[30:0], 1'b0};
              dsp_nxt  = dm1;
            end
            smx_pkg::K_IDIV: begin
              wq       = negq_r ? (~aresp.quo[31:0] + 32'd1) : aresp.quo[31:0];
              ds_wdata = {wq[30:0], 1'b0};
              dsp_nxt  = dm1;
            end
            default: begin
              ds_wdata = negq_r ? (~aresp.quo[31:0] + 32'd1) : aresp.quo[31:0];
              dsp_nxt  = dm1;
            end
          endcase
          ip_nxt    = nip;
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (fin) begin
      ov_nxt      = 1'b1;
      oaddr_nxt   = 16'(ip_nxt);
      oovalid_nxt = res_ov;
      oval_nxt    = res_val;
      ohalt_nxt   = stop_nxt;
      oerr_nxt    = err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      dsp_r   <= '0;
      csp_r   <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= 32'd0;
      end
      scr_r   <= 32'd0;
      ip_r    <= '0;
      stop_r  <= 1'b0;
      err_r   <= smx_pkg::E_NONE;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dsp_r   <= dsp_nxt;
      csp_r   <= csp_nxt;
      regs_r  <= regs_nxt;
      scr_r   <= scr_nxt;
      ip_r    <= ip_nxt;
      stop_r  <= stop_nxt;
      err_r   <= err_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    item_r    <= item_nxt;
    a_r       <= a_nxt;
    opv_r     <= opv_nxt;
    opbad_r   <= opbad_nxt;
    where_r   <= where_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    prod_r    <= prod_nxt;
    negq_r    <= negq_nxt;
    negr_r    <= negr_nxt;
    oaddr_r   <= oaddr_nxt;
    oovalid_r <= oovalid_nxt;
    oval_r    <= oval_nxt;
    ohalt_r   <= ohalt_nxt;
    oerr_r    <= oerr_nxt;
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      dstack[ds_waddr] <= ds_wdata;
    end
    ds_q <= dstack[ds_raddr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cstack[cs_waddr] <= cs_wdata;
    end
    cs_q <= cstack[cm1[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[ram_waddr] <= ram_wdata;
    end
    ram_q <= ram[opv_r[RAW-1:0]];
  end

  assign out_valid      = ov_r;
  assign out_next_addr  = oaddr_r;
  assign out_out_valid  = oovalid_r;
  assign out_out_value  = oval_r;
  assign out_halted     = ohalt_r;
  assign out_error_code = oerr_r;

endmodule

// ----- rtl/core/smx_checker.sv -----
module smx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [4:0]  in_kind,
  input logic [2:0]  in_arg_mode,
  input logic [2:0]  in_reg_index,
  input logic [31:0] in_immediate,
  input logic [15:0] in_jump_target,
  input logic [31:0] in_in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_next_addr,
  input logic        out_out_valid,
  input logic [31:0] out_out_value,
  input logic        out_halted,
  input logic [2:0]  out_error_code
);

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_addr)
      && $stable(out_error_code) && $stable(out_halted))
    else $error("stalled result changed");

  // An error code is only reported by a stopped machine.
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != 3'd0) |-> out_halted)
    else $error("error code without halt");

  // An out instruction never halts, and no value shows without it.
  a_out_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_valid |-> !out_halted)
    else $error("out value on a halted result");

  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_value == 32'd0)
    else $error("nonzero value without out");

endmodule

bind stack_machine_executor_core smx_checker u_smx_checker (.*);

// ----- sim/tb_stack_machine_executor_core.sv -----
module tb_stack_machine_executor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  localparam int DDEPTH = DATA_DEPTH_DEF;
  localparam int CDEPTH = CALL_DEPTH_DEF;
  localparam int NREGS = NUM_REGS_DEF;
  localparam int RWORDS = RAM_WORDS_DEF;
  // Cycles in which no transaction moves on either channel before the run is
  // abandoned. The limit must cover the RAM clearing pass after reset, the
  // slowest instruction and the longest receiver stall.
  localparam int IDLE_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic [4:0]  kind;
    logic [2:0]  mode;
    logic [2:0]  ri;
    logic [31:0] imm;
    logic [15:0] tgt;
    logic [31:0] inv;
  } instr_t;

  typedef struct {
    logic [15:0] nxt;
    logic        ov;
    logic [31:0] val;
    logic        halt;
    logic [2:0]  err;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_kind;
  logic [2:0]  in_arg_mode;
  logic [2:0]  in_reg_index;
  logic [31:0] in_immediate;
  logic [15:0] in_jump_target;
  logic [31:0] in_in_value;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_next_addr;
  logic        out_out_valid;
  logic [31:0] out_out_value;
  logic        out_halted;
  logic [2:0]  out_error_code;

  stack_machine_executor_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_arg_mode    (in_arg_mode),
    .in_reg_index   (in_reg_index),
    .in_immediate   (in_immediate),
    .in_jump_target (in_jump_target),
    .in_in_value    (in_in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_addr  (out_next_addr),
    .out_out_valid  (out_out_valid),
    .out_out_value  (out_out_value),
    .out_halted     (out_halted),
    .out_error_code (out_error_code)
  );

  // Shadow copy of the machine state. It is advanced once for every accepted
  // instruction transaction, in the order in which the block accepts them.
  logic [31:0] dstk [DDEPTH];
  int          dsp;
  logic [15:0] cstk [CDEPTH];
  int          csp;
  logic [31:0] regs [NREGS];
  logic [31:0] scr;
  logic [31:0] ram [RWORDS];
  logic [15:0] ip;
  logic        stop;
  logic [2:0]  err;

  // Status words predicted for accepted instructions, oldest first.
  status_t pending_status[$];
  int      mismatches;
  int      burst_left;
  int      idle_cycles;
  int      stall_left;
  int      rcv_style;
  int      rcv_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Largest r with r*r <= v, found one result bit at a time from the top.
  function automatic longint int_root(longint v);
    longint r;
    longint c;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      c = r + (longint'(1) << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Number of stack entries an instruction reads besides its operand field.
  function automatic int need_of(logic [4:0] kind);
    case (kind)
      K_ADD, K_SUB, K_DIV, K_MUL, K_MOD, K_IDIV, K_JNE, K_JGE, K_JE: return 2;
      K_POP, K_OUT, K_SQRT, K_SQR, K_JLZ, K_JGZ: return 1;
      default: return 0;
    endcase
  endfunction

  // Resolves a push or pop operand. where: 0 register, 1 scratch, 2 RAM.
  // Only reads the shadow state; the new scratch value is handed back in nscr.
  function automatic bit resolve(input logic [2:0] m, input logic [2:0] ri,
                                 input logic [31:0] imm, output logic [31:0] val,
                                 inout logic [31:0] nscr, output int where,
                                 output int idx);
    bit          have;
    logic [31:0] v;
    longint      ad;
    have = 1'b0;
    v = '0;
    where = 0;
    idx = 0;
    val = '0;
    if ((m & REG_BIT) != 0) begin
      if (int'(ri) >= NREGS) return 1'b0;
      v = regs[ri];
      idx = ri;
      have = 1'b1;
    end
    if ((m & CONSTANT_BIT) != 0) begin
      v = have ? v + imm : imm;
      nscr = v;
      where = 1;
      have = 1'b1;
    end
    if (!have) return 1'b0;
    if ((m & MEMORY_BIT) != 0) begin
      ad = sx(v);
      if (ad < 0 || ad >= RWORDS) return 1'b0;
      idx = int'(ad);
      where = 2;
      v = ram[idx];
    end
    val = v;
    return 1'b1;
  endfunction

  function automatic void fault(logic [2:0] code);
    stop = 1'b1;
    err = code;
  endfunction

  // True when the instruction would run without halting the machine.
  function automatic bit runs_clean(instr_t t);
    logic [31:0] v;
    logic [31:0] s;
    int          w;
    int          x;
    bit          ok;
    longint      top;
    top = (dsp > 0) ? sx(dstk[dsp-1]) : 0;
    s = scr;
    case (t.kind)
      K_PUSH, K_POP: begin
        ok = resolve(t.mode, t.ri, t.imm, v, s, w, x);
        return ok && (t.kind == K_PUSH ? dsp < DDEPTH : dsp > 0);
      end
      K_IN:   return dsp < DDEPTH;
      K_CALL: return csp < CDEPTH;
      K_RET:  return csp > 0;
      K_HLT:  return 1'b0;
      default: begin
        if (t.kind > K_JE || dsp < need_of(t.kind)) return 1'b0;
      end
    endcase
    if (t.kind == K_DIV) return top != 0;
    if (t.kind == K_MOD || t.kind == K_IDIV) return top / 2 != 0;
    if (t.kind == K_SQRT) return top / 2 >= 0;
    return 1'b1;
  endfunction

  // Executes one instruction on the shadow state and returns the status word
  // the block must report for it.
  function automatic status_t execute(instr_t t);
    status_t     r;
    logic [15:0] nip;
    int          d;
    longint      a;
    longint      b;
    longint      q;
    logic [31:0] v;
    logic [31:0] ns;
    logic [31:0] w;
    int          where;
    int          idx;
    bit          ok;
    r = '{default: '0};
    if (!stop) begin
      d = dsp;
      nip = ip + 16'd1;
      a = 0;
      b = 0;
      if (t.kind > K_JE) begin
        fault(E_UNKNOWN);
      end else if (t.kind == K_PUSH || t.kind == K_POP) begin
        ns = scr;
        ok = resolve(t.mode, t.ri, t.imm, v, ns, where, idx);
        if (!ok) fault(E_OPERAND);
        else if (t.kind == K_PUSH && d >= DDEPTH) fault(E_OVER);
        else if (t.kind == K_POP && d < 1) fault(E_UNDER);
        else begin
          ip = ip + 16'd2 + t.mode[0] + t.mode[1];
          scr = ns;
          if (t.kind == K_PUSH) begin
            dstk[d] = 32'(sx(v) * 2);
            dsp = d + 1;
          end else begin
            // Popping drops the fraction bit, rounding toward zero.
            w = 32'(sx(dstk[d-1]) / 2);
            dsp = d - 1;
            if (where == 0) regs[idx] = w;
            else if (where == 1) scr = w;
            else ram[idx] = w;
          end
        end
      end else if (d < need_of(t.kind)) begin
        fault(E_UNDER);
      end else begin
        if (d >= 1) a = sx(dstk[d-1]);
        if (d >= 2) b = sx(dstk[d-2]);
        case (t.kind)
          K_ADD: begin dstk[d-2] = 32'(b + a); dsp = d - 1; end
          K_SUB: begin dstk[d-2] = 32'(b - a); dsp = d - 1; end
          K_DIV: begin
            if (a == 0) fault(E_DIV_ZERO);
            else begin dstk[d-2] = 32'((2 * b) / a); dsp = d - 1; end
          end
          K_MUL: begin dstk[d-2] = 32'((b * a) / 2); dsp = d - 1; end
          K_IN: begin
            if (d >= DDEPTH) fault(E_OVER);
            else begin dstk[d] = 32'(sx(t.inv) * 2); dsp = d + 1; end
          end
          K_OUT: begin r.ov = 1'b1; r.val = dstk[d-1]; dsp = d - 1; end
          K_HLT: begin stop = 1'b1; err = E_NONE; end
          K_JMP: nip = t.tgt;
          K_CALL: begin
            if (csp >= CDEPTH) fault(E_OVER);
            else begin cstk[csp] = ip + 16'd2; csp++; nip = t.tgt; end
          end
          K_RET: begin
            if (csp < 1) fault(E_UNDER);
            else begin csp--; nip = cstk[csp]; end
          end
          K_SQRT: begin
            if (a / 2 < 0) fault(E_NEG_SQRT);
            else dstk[d-1] = 32'(int_root(a / 2) * 2);
          end
          K_SQR: begin q = a / 2; dstk[d-1] = 32'(q * q * 2); end
          K_MOD, K_IDIV: begin
            if (a / 2 == 0) fault(E_DIV_ZERO);
            else begin
              q = (t.kind == K_MOD) ? (b / 2) % (a / 2) : (b / 2) / (a / 2);
              dstk[d-2] = 32'(q * 2);
              dsp = d - 1;
            end
          end
          K_JNE: nip = (a != b) ? t.tgt : ip + 16'd2;
          K_JGE: nip = (a >= b) ? t.tgt : ip + 16'd2;
          K_JLZ: nip = (a < 0) ? t.tgt : ip + 16'd2;
          K_JGZ: nip = (a > 0) ? t.tgt : ip + 16'd2;
          K_JE:  nip = (a == b) ? t.tgt : ip + 16'd2;
          default: ;
        endcase
        // A fault or a halt leaves the instruction pointer on the instruction.
        if (!stop) ip = nip;
      end
    end
    r.nxt = ip;
    r.halt = stop;
    r.err = err;
    return r;
  endfunction

  // Sends one instruction transaction and records its predicted status once
  // the block accepts it. The sender works in bursts; between bursts valid
  // drops. Called with the time at a rising edge.
  task automatic send_instr(instr_t t);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_valid       <= 1'b1;
    in_kind        <= t.kind;
    in_arg_mode    <= t.mode;
    in_reg_index   <= t.ri;
    in_immediate   <= t.imm;
    in_jump_target <= t.tgt;
    in_in_value    <= t.inv;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(execute(t));
    burst_left--;
  endtask

  task automatic issue(logic [4:0] kind, logic [2:0] mode, logic [2:0] ri,
                       logic [31:0] imm, logic [31:0] inv);
    instr_t t;
    t.kind = kind;
    t.mode = mode;
    t.ri = ri;
    t.imm = imm;
    t.tgt = 16'($urandom);
    t.inv = inv;
    send_instr(t);
  endtask

  // A short program that walks through every opcode but sub and hlt, the extremes
  // of the immediate and the in value, and every operand addressing form.
  task automatic run_directed_program;
    issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'h7fff_ffff, 32'd0);
    issue(K_PUSH, CONSTANT_BIT, 3'd7, 32'h8000_0000, 32'd0);
    issue(K_ADD, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'd3, 32'd0);
    issue(K_MUL, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_PUSH, CONSTANT_BIT, 3'd0, -32'sd2, 32'd0);
    issue(K_DIV, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_IN, 3'd0, 3'd0, 32'd0, 32'h7fff_ffff);
    issue(K_JGE, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_JE, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_JNE, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_OUT, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_IN, 3'd0, 3'd0, 32'd0, 32'h8000_0000);
    issue(K_POP, REG_BIT, 3'd7, 32'd0, 32'd0);
    issue(K_PUSH, REG_BIT | MEMORY_BIT, 3'd7, 32'd0, 32'd0);
    issue(K_POP, 3'd7, 3'd7, 32'd1023, 32'd0);
    issue(K_PUSH, CONSTANT_BIT | MEMORY_BIT, 3'd0, 32'd1023, 32'd0);
    issue(K_POP, REG_BIT, 3'd1, 32'd0, 32'd0);
    issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'd50, 32'd0);
    issue(K_SQRT, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_SQR, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_MOD, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'd2, 32'd0);
    issue(K_IDIV, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_JLZ, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_JGZ, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_CALL, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_RET, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_JMP, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_DRAW, 3'd0, 3'd0, 32'd0, 32'd0);
    issue(K_POP, REG_BIT | CONSTANT_BIT, 3'd2, 32'd5, 32'd0);
  endtask

  // Random programs that keep the machine running: each candidate is checked
  // against the shadow state and drawn again if it would halt the machine.
  task automatic run_random_program;
    instr_t t;
    int     addr;
    repeat (RANDOM_ITEMS) begin
      do begin
        t.kind = 5'($urandom_range(0, 21));
        if (dsp < 3 && $urandom_range(0, 1) == 0) t.kind = K_PUSH;
        if (dsp > 48 && $urandom_range(0, 1) == 0) t.kind = K_POP;
        t.mode = 3'($urandom_range(1, 7));
        if ((t.mode & (REG_BIT | CONSTANT_BIT)) == 0) t.mode = t.mode | CONSTANT_BIT;
        t.ri = 3'($urandom);
        t.imm = $urandom;
        t.tgt = 16'($urandom);
        t.inv = $urandom;
        // Indirect operands mostly land on a few words so that values written
        // by pop are read back, with the far end of the RAM hit as well.
        if ((t.mode & MEMORY_BIT) != 0) begin
          addr = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                             : $urandom_range(0, RWORDS - 1);
          if ((t.mode & CONSTANT_BIT) == 0 && sx(regs[t.ri]) != longint'(addr))
            t.mode = t.mode | CONSTANT_BIT;
          if ((t.mode & CONSTANT_BIT) != 0)
            t.imm = 32'(addr) - (((t.mode & REG_BIT) != 0) ? regs[t.ri] : 32'd0);
        end
      end while (!runs_clean(t));
      send_instr(t);
    end
  endtask

  // Ends the program with one way of stopping, picked at random, and then
  // checks that the frozen status is returned for anything sent afterwards.
  task automatic run_fault_and_halt;
    logic [2:0] sel;
    instr_t     t;
    sel = 3'($urandom_range(0, 6));
    if (sel == E_OVER) begin
      while (dsp < DDEPTH) issue(K_PUSH, CONSTANT_BIT, 3'd0, $urandom, 32'd0);
    end else if (sel == E_UNDER) begin
      while (dsp > 0) issue(K_POP, REG_BIT, 3'($urandom), 32'd0, 32'd0);
    end else begin
      while (dsp > DDEPTH - 4) issue(K_POP, REG_BIT, 3'd0, 32'd0, 32'd0);
    end
    case (sel)
      E_NONE: issue(K_HLT, 3'd0, 3'd0, 32'd0, 32'd0);
      E_DIV_ZERO: begin
        issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'd5, 32'd0);
        issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'd0, 32'd0);
        issue(K_DIV, 3'd0, 3'd0, 32'd0, 32'd0);
      end
      E_NEG_SQRT: begin
        issue(K_PUSH, CONSTANT_BIT, 3'd0, 32'hffff_ffff, 32'd0);
        issue(K_SQRT, 3'd0, 3'd0, 32'd0, 32'd0);
      end
      E_UNKNOWN: issue(5'($urandom_range(22, 31)), 3'd0, 3'd0, 32'd0, 32'd0);
      E_UNDER: issue(K_POP, REG_BIT, 3'd0, 32'd0, 32'd0);
      E_OVER: issue(K_IN, 3'd0, 3'd0, 32'd0, $urandom);
      default: begin
        // Neither a register nor a constant selected, with or without
        // RAM indirection.
        issue(K_PUSH, ($urandom_range(0, 1) != 0) ? MEMORY_BIT : 3'd0, 3'd0,
              $urandom, 32'd0);
      end
    endcase
    repeat (8) begin
      t.kind = 5'($urandom);
      t.mode = 3'($urandom);
      t.ri = 3'($urandom);
      t.imm = $urandom;
      t.tgt = 16'($urandom);
      t.inv = $urandom;
      send_instr(t);
    end
  endtask

  // Receiver: out_ready follows a style that is drawn anew at regular
  // intervals, from always ready through short random stalls to long ones.
  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    status_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      rcv_style <= 0;
      rcv_count <= 0;
    end else begin
      rcv_count <= rcv_count + 1;
      if (rcv_count % 300 == 299) rcv_style <= $urandom_range(0, 2);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rcv_style == 1 && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (rcv_style == 2 && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(5, 23);
      end else begin
        out_ready <= 1'b1;
      end

      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transaction, next_addr %0h", out_next_addr);
        end else begin
          e = pending_status.pop_front();
          if (out_next_addr !== e.nxt || out_out_valid !== e.ov || out_out_value !== e.val ||
              out_halted !== e.halt || out_error_code !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected addr %0h ov %0b val %0h halt %0b err %0d, got %0h %0b %0h %0b %0d",
                       e.nxt, e.ov, e.val, e.halt, e.err, out_next_addr, out_out_valid,
                       out_out_value, out_halted, out_error_code);
          end
        end
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_arg_mode = '0;
    in_reg_index = '0;
    in_immediate = '0;
    in_jump_target = '0;
    in_in_value = '0;
    out_ready = 1'b0;
    idle_cycles = 0;
    mismatches = 0;
    burst_left = 0;
    dsp = 0;
    csp = 0;
    scr = '0;
    ip = '0;
    stop = 1'b0;
    err = E_NONE;
    foreach (regs[i]) regs[i] = '0;
    foreach (ram[i]) ram[i] = '0;
    foreach (dstk[i]) dstk[i] = '0;
    foreach (cstk[i]) cstk[i] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_program();
    run_random_program();
    run_fault_and_halt();

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    // Let a stray late result show up before the verdict.
    repeat (60) @(posedge clk);

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
